// ===== design/sorted_priority_queue_unit_assert.svh =====
// Assertion macros shared by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

// ===== design/spq_pkg.sv =====
// Types and constants of the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRIO_W   = 8;
	localparam int VALUE_W  = 32;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic        [VALUE_W-1:0] value;
	} entry_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   deq;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

// ===== design/sorted_priority_queue_unit.sv =====
// A result is registered and appears in the cycle after its command transaction.
// One command per cycle while the result side does not stall; every cell of the chain compares and
// shifts in parallel, so enqueue and dequeue both update the whole chain together.
// Output is held in a register, so input is taken while a result waits if it drains.
// Reset (arst_n low) empties the queue and drops any pending result;
// slot contents are not cleared and are read only below the fill count.
module sorted_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [7:0] priority_req, [39:8] payload
	input  logic        s_axis_tuser,  // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] dequeued_value, [33:32] status,
	                                   // [34] now_empty, [39:35] zero
);
	import spq_pkg::*;

	logic               accept;
	logic               full;
	logic               empty;
	cmd_t               cmd;
	cell_ctl_t          ctl;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t            out_status_q;
	logic               out_empty_q;
	status_t            status_d;

	entry_t entries  [CAPACITY];
	logic   gts      [CAPACITY];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);
	assign full          = (count_q == CNT_W'(CAPACITY));
	assign empty         = (count_q == '0);

	assign ctl.ins             = accept && (cmd == CMD_ENQ) && !full;
	assign ctl.deq             = accept && (cmd == CMD_DEQ) && !empty;
	assign ctl.new_entry.prio  = s_axis_tdata[7:0];
	assign ctl.new_entry.value = s_axis_tdata[39:8];

	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.deq) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		status_d = ST_OK;
		if (cmd == CMD_DEQ && empty) begin
			status_d = ST_EMPTY;
		end else if (cmd == CMD_ENQ && full) begin
			status_d = ST_FULL;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;

		if (i == 0) begin : g_head
			assign left_e = ctl.new_entry;
			assign left_g = 1'b1;
		end else begin : g_body
			assign left_e = entries[i-1];
			assign left_g = gts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CNT_W'(i) < count_q),
			.left_gt    (left_g),
			.left_entry (left_e),
			.right_entry(right_e),
			.entry      (entries[i]),
			.gt         (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q  <= ctl.deq ? entries[0].value : '0;
			out_status_q <= status_d;
			out_empty_q  <= (count_d == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_empty_q, out_status_q, out_value_q};

endmodule

// ===== design/spq_cell.sv =====
// One slot of the sorted queue: holds an entry, shifts left on dequeue, right on insert.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              left_gt,
	input  spq_pkg::entry_t   left_entry,
	input  spq_pkg::entry_t   right_entry,
	output spq_pkg::entry_t   entry,
	output logic              gt
);
	import spq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;

	// Stored entry outranks the new one strictly, so it stays put
	assign gt    = occupied && (entry_q.prio > ctl.new_entry.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.deq) begin
			entry_d = right_entry;
		end else if (ctl.ins && !gt) begin
			entry_d = left_gt ? ctl.new_entry : left_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	import spq_pkg::*;

	logic s_acc;
	logic m_wait;

	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign m_wait = m_axis_tvalid && !m_axis_tready;

	// Stalled result holds
	`SPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_wait, $stable(m_axis_tdata) && m_axis_tvalid)
	// Every command transaction yields a result next cycle
	`SPQ_ASSERT_NEXT(a_result_follows, clk, arst_n, s_acc, m_axis_tvalid)
	// Empty dequeue leaves an empty queue and no value
	`SPQ_ASSERT_IMPL(a_empty_deq, clk, arst_n,
		m_axis_tvalid && m_axis_tdata[33:32] == ST_EMPTY,
		m_axis_tdata[34] && m_axis_tdata[31:0] == '0)
	// Dropped enqueue means a full, non-empty queue
	`SPQ_ASSERT_IMPL(a_full_enq, clk, arst_n,
		m_axis_tvalid && m_axis_tdata[33:32] == ST_FULL,
		!m_axis_tdata[34] && m_axis_tdata[31:0] == '0)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

// ===== tb/sorted_priority_queue_unit_test.sv =====
// Self-checking testbench for the sorted priority queue: command streams checked against a local model.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic               now_empty;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [7:0] priority_req, [39:8] payload
	logic        s_axis_tuser;   // [0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] dequeued_value, [33:32] status, [34] now_empty

	// local copy of the queue contents
	logic signed [PRIO_W-1:0] model_prio  [CAPACITY];
	logic        [VALUE_W-1:0] model_value [CAPACITY];
	int                        model_fill = 0;

	outcome_t expected_outcomes[$];
	int       mismatches     = 0;
	int       cycle_count    = 0;
	int       src_max_gap    = 8;
	int       sink_max_stall = 8;
	int       sink_hold      = 0;

	sorted_priority_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic outcome_t predict_queue_outcome(cmd_t cmd, logic signed [PRIO_W-1:0] prio,
			logic [VALUE_W-1:0] payload);
		outcome_t res;
		int       pos;
		res.value  = '0;
		res.status = ST_OK;
		if (cmd == CMD_ENQ) begin
			if (model_fill >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				// new entry goes ahead of equal priorities
				while (pos < model_fill && model_prio[pos] > prio)
					pos++;
				for (int i = model_fill; i > pos; i--) begin
					model_prio[i]  = model_prio[i-1];
					model_value[i] = model_value[i-1];
				end
				model_prio[pos]  = prio;
				model_value[pos] = payload;
				model_fill++;
			end
		end else if (model_fill == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.value = model_value[0];
			for (int i = 1; i < model_fill; i++) begin
				model_prio[i-1]  = model_prio[i];
				model_value[i-1] = model_value[i];
			end
			model_fill--;
		end
		res.now_empty = (model_fill == 0);
		return res;
	endfunction

	// predict on each command transaction, check each result transaction
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_queue_outcome(cmd_t'(s_axis_tuser),
					s_axis_tdata[7:0], s_axis_tdata[39:8]);
				expected_outcomes.insert(expected_outcomes.size(), want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.value     = m_axis_tdata[31:0];
				got.status    = status_t'(m_axis_tdata[33:32]);
				got.now_empty = m_axis_tdata[34];
				if (expected_outcomes.size() == 0) begin
					$error("result transaction with nothing pending: tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_outcomes[0];
					expected_outcomes.delete(0);
					if (got.value !== want.value) begin
						$error("dequeued_value: expected %0d, actual %0d",
							$signed(want.value), $signed(got.value));
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						mismatches++;
					end
					if (got.now_empty !== want.now_empty) begin
						$error("now_empty: expected %0d, actual %0d", want.now_empty,
							got.now_empty);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold when a test asks for one
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = $urandom_range(sink_max_stall, 0);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// valid stays high on return so a back-to-back command needs no re-raise
	task automatic send_command(cmd_t cmd, logic [PRIO_W-1:0] prio, logic [VALUE_W-1:0] payload);
		int gap;
		gap = $urandom_range(src_max_gap, 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom(), 8'($urandom())};
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {payload, prio};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_queue();
		send_command(CMD_DEQ, 8'h00, 32'h0);
		send_command(CMD_DEQ, 8'hff, 32'hffff_ffff);
	endtask

	task automatic test_extreme_entries();
		send_command(CMD_ENQ, 8'h80, 32'h8000_0000);
		send_command(CMD_ENQ, 8'h7f, 32'h7fff_ffff);
		send_command(CMD_ENQ, 8'h00, 32'h0000_0000);
		send_command(CMD_ENQ, 8'hff, 32'hffff_ffff);
		// equal priorities: newest must come out first
		send_command(CMD_ENQ, 8'h05, 32'h0000_1111);
		send_command(CMD_ENQ, 8'h05, 32'h0000_2222);
		send_command(CMD_DEQ, 8'h00, 32'h0);
		send_command(CMD_DEQ, 8'h00, 32'h0);
	endtask

	task automatic test_full_queue();
		// four entries remain from the previous test
		for (int n = 0; n < CAPACITY - 4; n++)
			send_command(CMD_ENQ, 8'($urandom()), $urandom());
		send_command(CMD_ENQ, 8'h7f, 32'hdead_beef);
		send_command(CMD_DEQ, 8'h00, 32'h0);
	endtask

	task automatic test_random_traffic(int items, int gap_max, int stall_max);
		int               enq_pct;
		logic [PRIO_W-1:0] prio;
		cmd_t             cmd;
		src_max_gap    = gap_max;
		sink_max_stall = stall_max;
		enq_pct        = 50;
		for (int n = 0; n < items; n++) begin
			// drift the fill level so both full and empty get visited
			if (n % 40 == 0)
				enq_pct = 25 + 25 * $urandom_range(2, 0);
			if ($urandom_range(1, 0))
				prio = 8'($urandom());
			else
				prio = 8'($urandom_range(2, 0)) - 8'd1;
			cmd = ($urandom_range(99, 0) < enq_pct) ? CMD_ENQ : CMD_DEQ;
			send_command(cmd, prio, $urandom());
		end
	endtask

	task automatic test_backpressure();
		src_max_gap    = 0;
		sink_max_stall = 2;
		sink_hold      = 200;
		for (int n = 0; n < 30; n++)
			send_command(CMD_ENQ, 8'($urandom()), $urandom());
		wait_drained();
		for (int n = 0; n < 30; n++)
			send_command(($urandom_range(3, 0) == 0) ? CMD_ENQ : CMD_DEQ, 8'($urandom()),
				$urandom());
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_ENQ;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_extreme_entries();
		test_full_queue();
		test_random_traffic(300, 8, 8);
		test_random_traffic(200, 0, 0);
		test_backpressure();
		test_random_traffic(300, 8, 8);
		test_random_traffic(200, 2, 8);
		test_random_traffic(150, 8, 0);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
